// ===== rtl/fa_pkg.sv =====
package fa_pkg;

  localparam int NUM_FRAMES = 1024;
  localparam int MAX_OWNERS = 64;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int SW = $clog2(2 * NUM_FRAMES + 1);

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_REL   = 2'd2;

  localparam logic [1:0] KIND_PAGE = 2'd0;
  localparam logic [1:0] KIND_MAX  = 2'd2;

  typedef struct packed {
    logic        used;
    logic        refb;
    logic [1:0]  kind;
    logic [5:0]  owner;
    logic [19:0] page;
  } entry_t;

endpackage

// ===== rtl/frame_allocator_second_chance.sv =====
// allocate: a free-frame scan over up to NUM_FRAMES frames, then, with second chance
//   on and no frame free, a clock sweep of up to 2*NUM_FRAMES frame visits; free clears
//   one frame; release clears every used frame of the owner; one item at a time, as in_tready is high only in idle
// one result per item, held in an output register until taken
// reset: synchronous; a clearing pass zeroes the frame table before the first item
//   is taken; second chance resets on, clock hand to 0
module frame_allocator_second_chance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // frame_number, owner_id, virtual_page, frame_kind, pad
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // status, granted_frame, evicted, victim_owner, victim_page, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import fa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic [FW-1:0] inc(input logic [FW-1:0] a);
    inc = (a == FW'(NUM_FRAMES - 1)) ? '0 : a + 1'b1;
  endfunction

  entry_t mem [NUM_FRAMES];
  entry_t rd_data_r;
  logic [FW-1:0] rd_addr, wr_addr;
  entry_t wr_data;
  logic wr_en;

  logic [2:0] state_r, state_nxt;
  logic [FW-1:0] pos_r, pos_nxt, chk_r, hand_r, hand_nxt;
  logic [SW-1:0] step_r, step_nxt, limit;
  logic dv_r, dv_nxt, dlast_r, dlast_nxt;
  logic sc_r;
  logic [5:0] own_r, own_nxt;
  logic [19:0] page_r, page_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic res_st_r, res_st_nxt, res_ev_r, res_ev_nxt;
  logic [9:0] res_fr_r, res_fr_nxt;
  logic [5:0] res_vo_r, res_vo_nxt;
  logic [19:0] res_vp_r, res_vp_nxt;
  logic out_valid_r;
  logic [39:0] out_data_r;
  entry_t claim;

  logic [9:0] in_fnum;
  logic [5:0] in_own;
  logic [19:0] in_page;
  logic [1:0] in_kind;

  assign in_fnum = in_tdata[9:0];
  assign in_own  = in_tdata[15:10];
  assign in_page = in_tdata[35:16];
  assign in_kind = in_tdata[37:36];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign claim = '{used: 1'b1, refb: 1'b1, kind: kind_r, owner: own_r, page: page_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    step_nxt   = step_r;
    hand_nxt   = hand_r;
    dv_nxt     = 1'b0;
    dlast_nxt  = 1'b0;
    own_nxt    = own_r;
    page_nxt   = page_r;
    kind_nxt   = kind_r;
    res_st_nxt = res_st_r;
    res_fr_nxt = res_fr_r;
    res_ev_nxt = res_ev_r;
    res_vo_nxt = res_vo_r;
    res_vp_nxt = res_vp_r;
    wr_en      = 1'b0;
    wr_addr    = chk_r;
    wr_data    = '0;
    rd_addr    = pos_r;
    limit      = (state_r == S_SWEEP) ? SW'(2 * NUM_FRAMES) : SW'(NUM_FRAMES);

    if (state_r == S_SCAN || state_r == S_SWEEP || state_r == S_REL) begin
      if (step_r < limit) begin
        dv_nxt    = 1'b1;
        dlast_nxt = (step_r == limit - 1'b1);
        pos_nxt   = inc(pos_r);
        step_nxt  = step_r + 1'b1;
      end
    end

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        pos_nxt = inc(pos_r);
        if (pos_r == FW'(NUM_FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          own_nxt    = in_own;
          page_nxt   = in_page;
          kind_nxt   = in_kind;
          res_st_nxt = 1'b0;
          res_fr_nxt = '0;
          res_ev_nxt = 1'b0;
          res_vo_nxt = '0;
          res_vp_nxt = '0;
          pos_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = S_DONE;
          case (in_tuser)
            ACT_ALLOC: begin
              if (int'(in_own) >= MAX_OWNERS || in_kind > KIND_MAX) begin
                res_st_nxt = 1'b1;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_FREE: begin
              if (int'(in_fnum) >= NUM_FRAMES) begin
                res_st_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = FW'(in_fnum);
              end
            end
            ACT_REL: state_nxt = S_REL;
            default: res_st_nxt = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (dv_r) begin
          if (!rd_data_r.used) begin
            wr_en      = 1'b1;
            wr_data    = claim;
            res_fr_nxt = 10'(chk_r);
            state_nxt  = S_DONE;
          end else if (dlast_r) begin
            if (!sc_r) begin
              res_st_nxt = 1'b1;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = hand_r;
              step_nxt  = '0;
              dv_nxt    = 1'b0;
              state_nxt = S_SWEEP;
            end
          end
        end
      end
      S_SWEEP: begin
        if (dv_r) begin
          if (rd_data_r.kind == KIND_PAGE && !rd_data_r.refb) begin
            wr_en      = 1'b1;
            wr_data    = claim;
            hand_nxt   = inc(chk_r);
            res_fr_nxt = 10'(chk_r);
            res_ev_nxt = 1'b1;
            res_vo_nxt = rd_data_r.owner;
            res_vp_nxt = rd_data_r.page;
            state_nxt  = S_DONE;
          end else begin
            if (rd_data_r.kind == KIND_PAGE) begin
              wr_en        = 1'b1;
              wr_data      = rd_data_r;
              wr_data.refb = 1'b0;
            end
            if (dlast_r) begin
              res_st_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
          end
        end
      end
      S_REL: begin
        if (dv_r) begin
          if (rd_data_r.used && rd_data_r.owner == own_r) begin
            wr_en = 1'b1;
          end
          if (dlast_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (state_nxt == S_DONE) begin
      dv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      step_r      <= '0;
      hand_r      <= '0;
      dv_r        <= 1'b0;
      dlast_r     <= 1'b0;
      sc_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
      hand_r  <= hand_nxt;
      dv_r    <= dv_nxt;
      dlast_r <= dlast_nxt;
      if (cfg_valid) begin
        sc_r <= cfg_data;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r    <= pos_r;
    own_r    <= own_nxt;
    page_r   <= page_nxt;
    kind_r   <= kind_nxt;
    res_st_r <= res_st_nxt;
    res_fr_r <= res_fr_nxt;
    res_ev_r <= res_ev_nxt;
    res_vo_r <= res_vo_nxt;
    res_vp_r <= res_vp_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {2'b00, res_vp_r, res_vo_r, res_ev_r, res_fr_r, res_st_r};
    end
  end

endmodule

// ===== rtl/fa_checker.sv =====
module fa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[39:1] == 39'd0)
    else $error("failed result carries data");

  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> !out_tdata[0])
    else $error("eviction with failure status");

endmodule

bind frame_allocator_second_chance fa_checker u_fa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_frame_allocator_second_chance.sv =====
module tb_frame_allocator_second_chance;
  timeunit 1ns;
  timeprecision 1ps;
  import fa_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [1:0] ACT_BAD = 2'd3;
  localparam logic [1:0] KIND_TABLE = 2'd1;
  localparam logic [1:0] KIND_DIR = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct {
    logic        status;
    logic [9:0]  frame;
    logic        evicted;
    logic [5:0]  vowner;
    logic [19:0] vpage;
  } grant_t;

  class alloc_scoreboard;
    bit          used [NUM_FRAMES];
    logic [5:0]  owner [NUM_FRAMES];
    logic [19:0] page [NUM_FRAMES];
    logic [1:0]  kind [NUM_FRAMES];
    bit          refb [NUM_FRAMES];
    int          hand;
    bit          sc_on;
    grant_t      pending [$];
    int          mismatches;
    int          orphans;

    function new();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        used[i] = 0; owner[i] = 0; page[i] = 0; kind[i] = 0; refb[i] = 0;
      end
      hand = 0;
      sc_on = 1;
      mismatches = 0;
      orphans = 0;
    endfunction

    function void clear_entry(int f);
      used[f] = 0; owner[f] = 0; page[f] = 0; kind[f] = 0; refb[f] = 0;
    endfunction

    function void claim(int f, logic [5:0] o, logic [19:0] p, logic [1:0] k);
      used[f] = 1; owner[f] = o; page[f] = p; kind[f] = k; refb[f] = 1;
    endfunction

    function grant_t allocate(logic [5:0] o, logic [19:0] p, logic [1:0] k);
      grant_t r;
      int pos;
      r = '{1'b1, 10'd0, 1'b0, 6'd0, 20'd0};
      if (int'(o) >= MAX_OWNERS || k > KIND_MAX) return r;
      for (int f = 0; f < NUM_FRAMES; f++)
        if (!used[f]) begin
          claim(f, o, p, k);
          r.status = 0;
          r.frame = f[9:0];
          return r;
        end
      if (!sc_on) return r;
      pos = hand;
      for (int s = 0; s < 2 * NUM_FRAMES; s++) begin
        if (kind[pos] == KIND_PAGE) begin
          if (refb[pos]) refb[pos] = 0;
          else begin
            r = '{1'b0, pos[9:0], 1'b1, owner[pos], page[pos]};
            claim(pos, o, p, k);
            hand = (pos + 1) % NUM_FRAMES;
            return r;
          end
        end
        pos = (pos + 1) % NUM_FRAMES;
      end
      return r;
    endfunction

    function void note_request(logic [1:0] a, logic [9:0] fn, logic [5:0] o,
                               logic [19:0] p, logic [1:0] k);
      grant_t r;
      r = '{1'b0, 10'd0, 1'b0, 6'd0, 20'd0};
      case (a)
        ACT_ALLOC: r = allocate(o, p, k);
        ACT_FREE: begin
          if (int'(fn) >= NUM_FRAMES) r.status = 1;
          else clear_entry(fn);
        end
        ACT_REL: begin
          for (int f = 0; f < NUM_FRAMES; f++)
            if (used[f] && owner[f] == o) clear_entry(f);
        end
        default: r.status = 1;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [39:0] d);
      grant_t e;
      grant_t g;
      g = '{d[0], d[10:1], d[11], d[17:12], d[37:18]};
      if (pending.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status || g.frame !== e.frame || g.evicted !== e.evicted ||
          g.vowner !== e.vowner || g.vpage !== e.vpage) begin
        mismatches++;
        if (mismatches + orphans <= 10)
          $display("mismatch: expected st=%0d fr=%0d ev=%0d vo=%0d vp=%h, %s",
                   e.status, e.frame, e.evicted, e.vowner, e.vpage,
                   $sformatf("got st=%0d fr=%0d ev=%0d vo=%0d vp=%h",
                             g.status, g.frame, g.evicted, g.vowner, g.vpage));
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_data = 0;

  alloc_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  quiet = 0;
  bit  held = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  frame_allocator_second_chance dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!held && sent >= 30) begin
      held <= 1;
      hold_left <= 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  task automatic send(logic [1:0] a, logic [9:0] fn, logic [5:0] o,
                      logic [19:0] p, logic [1:0] k);
    in_tvalid <= 1;
    in_tuser <= a;
    in_tdata <= {2'b00, k, p, o, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(a, fn, o, p, k);
    sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    wait_idle();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.sc_on = v;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [1:0] k;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) < 7) ? KIND_PAGE : 2'($urandom_range(0, 3));
    if (r < 50) send(ACT_ALLOC, 10'($urandom), 6'($urandom), 20'($urandom), k);
    else if (r < 82) send(ACT_FREE, 10'($urandom), 6'($urandom), 20'($urandom), 2'($urandom));
    else if (r < 94) send(ACT_REL, 10'($urandom), 6'($urandom), 20'($urandom), 2'($urandom));
    else send(ACT_BAD, 10'($urandom), 6'($urandom), 20'($urandom), 2'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_mode(1);
    // directed: empty table, every action, field extremes
    send(ACT_ALLOC, 10'd0, 6'd63, 20'hFFFFF, KIND_PAGE);
    send(ACT_ALLOC, 10'h3FF, 6'd0, 20'h00000, KIND_TABLE);
    send(ACT_ALLOC, 10'd5, 6'd63, 20'h12345, KIND_DIR);
    send(ACT_ALLOC, 10'd0, 6'd1, 20'hABCDE, KIND_BAD);
    send(ACT_BAD, 10'h3FF, 6'd63, 20'hFFFFF, KIND_BAD);
    send(ACT_FREE, 10'd1, 6'd0, 20'd0, KIND_PAGE);
    send(ACT_FREE, 10'h3FF, 6'd63, 20'hFFFFF, KIND_BAD);
    send(ACT_FREE, 10'd1, 6'd0, 20'd0, KIND_PAGE);
    send(ACT_ALLOC, 10'd0, 6'd7, 20'h55555, KIND_PAGE);
    send(ACT_REL, 10'd0, 6'd63, 20'd0, KIND_PAGE);
    send(ACT_REL, 10'h3FF, 6'd20, 20'hFFFFF, KIND_BAD);
    send(ACT_ALLOC, 10'd0, 6'd0, 20'hAAAAA, KIND_PAGE);
    for (int i = 0; i < 278; i++) begin
      if (i == 230) quiet = 1;
      if (i % 60 == 59) write_mode(($urandom_range(0, 2) != 0) ? 1'b1 : 1'b0);
      if (i == 200) write_mode(1);
      random_item();
    end
    wait_idle();
    repeat (3 * NUM_FRAMES + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
